/* rtl/smpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// shared types, codes and default sizes of the stable max priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEF_QUEUE_DEPTH   = 64;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_TAG_BITS      = 16;

    localparam int STATUS_BITS = 2;

    // opcode of an input item
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status of a result item
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

    // broadcast command to every cell of the chain
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } t_cell_cmd;

endpackage : smpq_pkg
`default_nettype wire

/* rtl/smpq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_cell
// one slot of the sorted chain: keeps, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module smpq_cell #(
    parameter int PRIORITY_BITS = smpq_pkg::DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = smpq_pkg::DEF_TAG_BITS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire smpq_pkg::t_cell_cmd        i_cmd,
    input  wire logic signed [PRIORITY_BITS-1:0] i_new_prio,
    input  wire logic [TAG_BITS-1:0]        i_new_tag,
    // neighbor toward the head
    input  wire                             i_prev_valid,
    input  wire logic signed [PRIORITY_BITS-1:0] i_prev_prio,
    input  wire logic [TAG_BITS-1:0]        i_prev_tag,
    input  wire                             i_prev_ge,
    // neighbor toward the tail
    input  wire                             i_next_valid,
    input  wire logic signed [PRIORITY_BITS-1:0] i_next_prio,
    input  wire logic [TAG_BITS-1:0]        i_next_tag,
    output logic                            o_valid,
    output logic signed [PRIORITY_BITS-1:0] o_prio,
    output logic [TAG_BITS-1:0]             o_tag,
    output logic                            o_ge
);
    import smpq_pkg::*;

    logic                            r_valid;
    logic signed [PRIORITY_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]             r_tag;
    logic                            n_valid;
    logic signed [PRIORITY_BITS-1:0] n_prio;
    logic [TAG_BITS-1:0]             n_tag;

    // new entry goes behind this one
    assign o_ge = r_valid && (r_prio >= i_new_prio);

    always_comb begin
        n_valid = r_valid;
        n_prio  = r_prio;
        n_tag   = r_tag;
        if (i_cmd.remove_en) begin
            n_valid = i_next_valid;
            n_prio  = i_next_prio;
            n_tag   = i_next_tag;
        end else if (i_cmd.insert_en && !o_ge) begin
            if (i_prev_ge) begin
                n_valid = 1'b1;
                n_prio  = i_new_prio;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_prev_valid;
                n_prio  = i_prev_prio;
                n_tag   = i_prev_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

    assign o_valid = r_valid;
    assign o_prio  = r_prio;
    assign o_tag   = r_tag;

endmodule : smpq_cell
`default_nettype wire

/* rtl/stable_max_priority_queue_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stable_max_priority_queue_unit
// sorted systolic priority queue, highest priority first, oldest first on ties
// ----------------------------------------------------------------------------
//  channel   direction  tdata (lsb first)              tuser
//  s_*       in         priority_req, tag, zero pad     opcode
//  m_*       out        served_tag, occupancy, zero pad status
//
//  one transfer in and one registered result out per cycle while m_tready is high;
//  the rate is set by the chain of cells, each comparing its own slot with the
//  new priority in parallel and shifting toward head or tail in one step
//  reset clears the valid bit of every cell and the count at once, no sweep
//  a result held in the output register while m_tready is low stalls s_tready
// ----------------------------------------------------------------------------
module stable_max_priority_queue_unit #(
    parameter int QUEUE_DEPTH   = smpq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = smpq_pkg::DEF_PRIORITY_BITS,
    parameter int TAG_BITS      = smpq_pkg::DEF_TAG_BITS
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    // input stream
    input  wire  s_tvalid,
    output logic s_tready,
    // priority_req, tag, zero pad
    input  wire logic [((PRIORITY_BITS+TAG_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire logic                                      s_tuser,
    // result stream
    output logic m_tvalid,
    input  wire  m_tready,
    // served_tag, occupancy, zero pad
    output logic [((TAG_BITS+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [smpq_pkg::STATUS_BITS-1:0]                   m_tuser
);
    import smpq_pkg::*;

    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W   = ((TAG_BITS + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // input fields
    logic                            w_accept;
    logic                            w_op;
    logic signed [PRIORITY_BITS-1:0] w_new_prio;
    logic [TAG_BITS-1:0]             w_new_tag;
    logic                            w_empty;
    logic                            w_full;
    t_cell_cmd                       w_cmd;

    // chain taps
    logic                            w_valid [QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] w_prio  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]             w_tag   [QUEUE_DEPTH];
    logic                            w_ge    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]          w_valid_vec;

    // count and output register
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_m_valid;
    logic [STATUS_BITS-1:0] r_status;
    logic [STATUS_BITS-1:0] n_status;
    logic [TAG_BITS-1:0]    r_served;
    logic [TAG_BITS-1:0]    n_served;

    assign s_tready   = !r_m_valid || m_tready;
    assign w_accept   = s_tvalid && s_tready;
    assign w_op       = s_tuser;
    assign w_new_prio = $signed(s_tdata[PRIORITY_BITS-1:0]);
    assign w_new_tag  = s_tdata[PRIORITY_BITS +: TAG_BITS];
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == FULL_CNT);

    // cells only move on a transfer that really changes the store
    assign w_cmd.insert_en = w_accept && (w_op == OP_INSERT) && !w_full;
    assign w_cmd.remove_en = w_accept && (w_op == OP_REMOVE) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                            w_pv;
            logic signed [PRIORITY_BITS-1:0] w_pp;
            logic [TAG_BITS-1:0]             w_pt;
            logic                            w_pg;
            logic                            w_nv;
            logic signed [PRIORITY_BITS-1:0] w_np;
            logic [TAG_BITS-1:0]             w_nt;

            if (g == 0) begin : g_head
                // head takes the new entry unless it stays in front of it
                assign w_pv = 1'b0;
                assign w_pp = '0;
                assign w_pt = '0;
                assign w_pg = 1'b1;
            end else begin : g_body
                assign w_pv = w_valid[g-1];
                assign w_pp = w_prio[g-1];
                assign w_pt = w_tag[g-1];
                assign w_pg = w_ge[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_np = '0;
                assign w_nt = '0;
            end else begin : g_inner
                assign w_nv = w_valid[g+1];
                assign w_np = w_prio[g+1];
                assign w_nt = w_tag[g+1];
            end

            smpq_cell #(
                .PRIORITY_BITS(PRIORITY_BITS),
                .TAG_BITS     (TAG_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_new_prio  (w_new_prio),
                .i_new_tag   (w_new_tag),
                .i_prev_valid(w_pv),
                .i_prev_prio (w_pp),
                .i_prev_tag  (w_pt),
                .i_prev_ge   (w_pg),
                .i_next_valid(w_nv),
                .i_next_prio (w_np),
                .i_next_tag  (w_nt),
                .o_valid     (w_valid[g]),
                .o_prio      (w_prio[g]),
                .o_tag       (w_tag[g]),
                .o_ge        (w_ge[g])
            );

            assign w_valid_vec[g] = w_valid[g];
        end
    endgenerate

    // result of the accepted item
    always_comb begin
        n_count  = r_count;
        n_status = ST_INSERTED;
        n_served = '0;
        unique case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_REMOVED;
                    n_served = w_tag[0];
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_INSERTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_served <= n_served;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = OUT_W'({r_count, r_served});

    // valid cells always form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, w_valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1}))
        else $error("valid cells are not contiguous from the head");

    // the count tracks the number of occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("entry count differs from occupied cells");

    // a remove on an empty store reports an empty error
    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_REMOVE) && w_empty)
        |=> (m_tvalid && (m_tuser == ST_EMPTY) && (r_count == '0)))
        else $error("remove on empty not reported");

    // an insert on a full store leaves the count unchanged and reports full
    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_INSERT) && w_full)
        |=> ((m_tuser == ST_FULL) && (r_count == FULL_CNT)))
        else $error("insert on full not reported");

endmodule : stable_max_priority_queue_unit
`default_nettype wire
